// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clk edge while reset is released.
`define BPTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds while reset is released.
`define BPTS_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/bpts_pkg.sv =====
// Shared types and constants of the bitmap priority task scheduler.
package bpts_pkg;

  localparam int PRIO_W   = 6;
  localparam int REQ_W    = 5;
  localparam int WORD_W   = 32;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 3;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 80;

  localparam logic [CMD_W-1:0] CMD_CALL    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RAISE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTORE = 2'd2;

  localparam logic [STAT_W-1:0] ST_RUN_NOW    = 3'd0;
  localparam logic [STAT_W-1:0] ST_QUEUED     = 3'd1;
  localparam logic [STAT_W-1:0] ST_DROPPED    = 3'd2;
  localparam logic [STAT_W-1:0] ST_DISPATCH   = 3'd3;
  localparam logic [STAT_W-1:0] ST_RESUME     = 3'd4;
  localparam logic [STAT_W-1:0] ST_RAISED     = 3'd5;
  localparam logic [STAT_W-1:0] ST_NOT_RAISED = 3'd6;

  localparam logic [PRIO_W-1:0] PRIO_IDLE = 6'h3f;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LATCH,
    OP_RUN,
    OP_RAISE,
    OP_NOT_RAISED,
    OP_DROP,
    OP_RESUME,
    OP_ENQ_RD,
    OP_ENQ_NEW,
    OP_ENQ_TRD,
    OP_ENQ_LNK,
    OP_ENQ_FIN,
    OP_DQ_TAIL,
    OP_DQ_LAST,
    OP_DQ_FIRST,
    OP_DQ_UNLINK,
    OP_DQ_FREE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             run_ok;
    logic             free_empty;
    logic             resume;
    logic             level_pend;
  } dp_stat_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] run_func;
    logic [WORD_W-1:0] run_message;
    logic [PRIO_W-1:0] result_priority;
    logic [PRIO_W-1:0] now_priority;
  } result_t;

endpackage

// ===== rtl/bpts_ctrl.sv =====
// Sequencer of the scheduler: steps the datapath through each request.
module bpts_ctrl
  import bpts_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_busy,
  input  dp_stat_t stat,
  output dp_cmd_t  dcmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_ENQ_SEL,
    S_ENQ_LNK,
    S_ENQ_FIN,
    S_DQ_LAST,
    S_DQ_FIRST,
    S_DQ_UNLINK,
    S_DQ_FREE
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    dcmd.op   = OP_NOP;
    dcmd.emit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dcmd.op   = OP_LATCH;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.cmd)
          CMD_CALL: begin
            if (stat.run_ok || stat.free_empty) begin
              if (!out_busy) begin
                dcmd.op   = stat.run_ok ? OP_RUN : OP_DROP;
                dcmd.emit = 1'b1;
                state_nxt = S_IDLE;
              end
            end else begin
              dcmd.op   = OP_ENQ_RD;
              state_nxt = S_ENQ_SEL;
            end
          end
          CMD_RAISE: begin
            if (!out_busy) begin
              dcmd.op   = stat.run_ok ? OP_RAISE : OP_NOT_RAISED;
              dcmd.emit = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          CMD_RESTORE: begin
            if (stat.resume) begin
              if (!out_busy) begin
                dcmd.op   = OP_RESUME;
                dcmd.emit = 1'b1;
                state_nxt = S_IDLE;
              end
            end else begin
              dcmd.op   = OP_DQ_TAIL;
              state_nxt = S_DQ_LAST;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_ENQ_SEL: begin
        if (stat.level_pend) begin
          dcmd.op   = OP_ENQ_TRD;
          state_nxt = S_ENQ_LNK;
        end else if (!out_busy) begin
          dcmd.op   = OP_ENQ_NEW;
          dcmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ENQ_LNK: begin
        dcmd.op   = OP_ENQ_LNK;
        state_nxt = S_ENQ_FIN;
      end
      S_ENQ_FIN: begin
        if (!out_busy) begin
          dcmd.op   = OP_ENQ_FIN;
          dcmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DQ_LAST: begin
        dcmd.op   = OP_DQ_LAST;
        state_nxt = S_DQ_FIRST;
      end
      S_DQ_FIRST: begin
        dcmd.op   = OP_DQ_FIRST;
        state_nxt = S_DQ_UNLINK;
      end
      S_DQ_UNLINK: begin
        dcmd.op   = OP_DQ_UNLINK;
        state_nxt = S_DQ_FREE;
      end
      S_DQ_FREE: begin
        if (!out_busy) begin
          dcmd.op   = OP_DQ_FREE;
          dcmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/bpts_dpath.sv =====
// Scheduler datapath: priority state, level bitmap, queue memories, free list.
`include "assert_macros.svh"

module bpts_dpath
  import bpts_pkg::*;
#(
  parameter int PRIORITY_LEVELS = 32,
  parameter int NODE_COUNT      = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [REQ_W-1:0]  in_req,
  input  logic [PRIO_W-1:0] in_prev,
  input  logic [WORD_W-1:0] in_func,
  input  logic [WORD_W-1:0] in_msg,
  input  dp_cmd_t           dcmd,
  output dp_stat_t          stat,
  output result_t           res
);

  localparam int LW = $clog2(PRIORITY_LEVELS);
  localparam int NW = $clog2(NODE_COUNT);
  localparam int CW = $clog2(NODE_COUNT + 1);

  // Highest set level of the bitmap, all ones when the bitmap is empty.
  function automatic logic [PRIO_W-1:0] top_level(input logic [PRIORITY_LEVELS-1:0] bits);
    logic [PRIO_W-1:0] top;
    top = PRIO_IDLE;
    for (int i = 0; i < PRIORITY_LEVELS; i++) begin
      if (bits[i]) top = PRIO_W'(i);
    end
    return top;
  endfunction

  // Latched request.
  logic [CMD_W-1:0]         cmd_r;
  logic [REQ_W-1:0]         req_r;
  logic signed [PRIO_W-1:0] prev_r;
  logic [WORD_W-1:0]        func_r;
  logic [WORD_W-1:0]        msg_r;

  // Scheduler state.
  logic signed [PRIO_W-1:0] cur_r;
  logic signed [PRIO_W-1:0] hp_r;
  logic [PRIORITY_LEVELS-1:0] pending_r;
  logic [NW-1:0]            free_head_r;
  logic [CW-1:0]            fresh_r;
  logic [CW-1:0]            rec_cnt_r;

  // Work registers of the multi-cycle sequences.
  logic [NW-1:0]            node_n_r;
  logic [NW-1:0]            tail_t_r;
  logic [NW-1:0]            first_r;
  logic [LW-1:0]            lvl_r;

  // Memories and their registered read data.
  logic [NW-1:0]     tail_mem [PRIORITY_LEVELS];
  logic [NW-1:0]     link_mem [NODE_COUNT];
  logic [WORD_W-1:0] func_mem [NODE_COUNT];
  logic [WORD_W-1:0] msg_mem  [NODE_COUNT];
  logic [NW-1:0]     tail_rd_r;
  logic [NW-1:0]     link_rd_r;
  logic [WORD_W-1:0] func_rd_r;
  logic [WORD_W-1:0] msg_rd_r;

  logic [LW-1:0]     tail_raddr;
  logic              tail_we;
  logic [NW-1:0]     link_raddr;
  logic              link_we;
  logic [NW-1:0]     link_waddr;
  logic [NW-1:0]     link_wdata;
  logic [NW-1:0]     node_raddr;
  logic              node_we;

  logic [LW-1:0]     lvl_req;
  logic [LW-1:0]     lvl_hp;
  logic              use_rec;
  logic [REQ_W-1:0]  req_sat;
  logic [PRIO_W-1:0] prev_clamp;
  logic signed [PRIO_W-1:0] req_prio;

  assign lvl_req  = LW'(req_r);
  assign lvl_hp   = LW'(hp_r);
  assign use_rec  = (rec_cnt_r != '0);
  assign req_prio = $signed({1'b0, req_r});

  assign req_sat    = ({2'b00, in_req} > 7'(PRIORITY_LEVELS - 1)) ?
                      REQ_W'(PRIORITY_LEVELS - 1) : in_req;
  assign prev_clamp = (in_prev[PRIO_W-1] && (in_prev != PRIO_IDLE)) ? PRIO_IDLE : in_prev;

  assign stat.cmd        = cmd_r;
  assign stat.run_ok     = (req_prio >= cur_r);
  assign stat.free_empty = !use_rec && (fresh_r == CW'(NODE_COUNT));
  assign stat.resume     = (hp_r <= prev_r);
  assign stat.level_pend = pending_r[lvl_req];

  // Memory addressing per operation.
  always_comb begin
    tail_raddr = lvl_req;
    tail_we    = 1'b0;
    link_raddr = free_head_r;
    link_we    = 1'b0;
    link_waddr = node_n_r;
    link_wdata = link_rd_r;
    node_raddr = first_r;
    node_we    = 1'b0;
    case (dcmd.op)
      OP_ENQ_NEW: begin
        node_we    = 1'b1;
        link_we    = 1'b1;
        link_wdata = node_n_r;
        tail_we    = 1'b1;
      end
      OP_ENQ_TRD: begin
        node_we    = 1'b1;
        link_raddr = tail_rd_r;
      end
      OP_ENQ_LNK: link_we = 1'b1;
      OP_ENQ_FIN: begin
        link_we    = 1'b1;
        link_waddr = tail_t_r;
        link_wdata = node_n_r;
        tail_we    = 1'b1;
      end
      OP_DQ_TAIL:  tail_raddr = lvl_hp;
      OP_DQ_LAST:  link_raddr = tail_rd_r;
      OP_DQ_FIRST: begin
        link_raddr = link_rd_r;
        node_raddr = link_rd_r;
      end
      OP_DQ_UNLINK: begin
        link_we    = (first_r != tail_t_r);
        link_waddr = tail_t_r;
      end
      OP_DQ_FREE: begin
        link_we    = 1'b1;
        link_waddr = first_r;
        link_wdata = free_head_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tail_we) tail_mem[lvl_req] <= node_n_r;
    tail_rd_r <= tail_mem[tail_raddr];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    link_rd_r <= link_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      func_mem[node_n_r] <= func_r;
      msg_mem[node_n_r]  <= msg_r;
    end
    func_rd_r <= func_mem[node_raddr];
    msg_rd_r  <= msg_mem[node_raddr];
  end

  // Scheduler state and free list.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= PRIO_IDLE;
      hp_r        <= PRIO_IDLE;
      pending_r   <= '0;
      free_head_r <= '0;
      fresh_r     <= '0;
      rec_cnt_r   <= '0;
    end else begin
      hp_r <= top_level(pending_r);
      case (dcmd.op)
        OP_RUN, OP_RAISE: cur_r <= req_prio;
        OP_RESUME:        cur_r <= prev_r;
        OP_ENQ_NEW, OP_ENQ_TRD: begin
          // Take a recycled node if any, else the next never-used one.
          if (use_rec) begin
            free_head_r <= link_rd_r;
            rec_cnt_r   <= rec_cnt_r - CW'(1);
          end else begin
            fresh_r <= fresh_r + CW'(1);
          end
          if (dcmd.op == OP_ENQ_NEW) pending_r[lvl_req] <= 1'b1;
        end
        OP_DQ_UNLINK: begin
          if (first_r == tail_t_r) pending_r[lvl_r] <= 1'b0;
        end
        OP_DQ_FREE: begin
          free_head_r <= first_r;
          rec_cnt_r   <= rec_cnt_r + CW'(1);
          cur_r       <= $signed(PRIO_W'(lvl_r));
        end
        default: ;
      endcase
    end
  end

  // Request and work registers.
  always_ff @(posedge clk) begin
    case (dcmd.op)
      OP_LATCH: begin
        cmd_r  <= in_cmd;
        req_r  <= req_sat;
        prev_r <= prev_clamp;
        func_r <= in_func;
        msg_r  <= in_msg;
      end
      OP_ENQ_RD:   node_n_r <= use_rec ? free_head_r : NW'(fresh_r);
      OP_ENQ_TRD:  tail_t_r <= tail_rd_r;
      OP_DQ_TAIL:  lvl_r    <= lvl_hp;
      OP_DQ_LAST:  tail_t_r <= tail_rd_r;
      OP_DQ_FIRST: first_r  <= link_rd_r;
      default: ;
    endcase
  end

  // Result of the operation that emits.
  always_comb begin
    res.status          = ST_RUN_NOW;
    res.run_func        = '0;
    res.run_message     = '0;
    res.result_priority = cur_r;
    res.now_priority    = cur_r;
    case (dcmd.op)
      OP_RUN: begin
        res.run_func     = func_r;
        res.run_message  = msg_r;
        res.now_priority = req_prio;
      end
      OP_RAISE: begin
        res.status       = ST_RAISED;
        res.now_priority = req_prio;
      end
      OP_NOT_RAISED: res.status = ST_NOT_RAISED;
      OP_DROP: begin
        res.status          = ST_DROPPED;
        res.result_priority = req_prio;
      end
      OP_RESUME: begin
        res.status          = ST_RESUME;
        res.result_priority = prev_r;
        res.now_priority    = prev_r;
      end
      OP_ENQ_NEW, OP_ENQ_FIN: begin
        res.status          = ST_QUEUED;
        res.result_priority = req_prio;
      end
      OP_DQ_FREE: begin
        res.status          = ST_DISPATCH;
        res.run_func        = func_rd_r;
        res.run_message     = msg_rd_r;
        res.result_priority = PRIO_W'(lvl_r);
        res.now_priority    = PRIO_W'(lvl_r);
      end
      default: ;
    endcase
  end

  `BPTS_ASSERT(a_free_list_count, rec_cnt_r <= fresh_r, "more recycled nodes than allocated")
  `BPTS_ASSERT(a_dispatch_has_work, dcmd.op == OP_DQ_TAIL |-> pending_r != '0,
               "dispatch started with no level pending")

endmodule

// ===== rtl/bitmap_priority_task_scheduler_unit.sv =====
// Top level of the bitmap priority task scheduler: ports, output register, sequencer, datapath.
//
// Usage. Requests arrive on the in_ stream: in_tuser carries the command (call, raise,
// restore) and in_tdata carries the priority, the previous priority and the task words.
// Every request except the unused command code produces exactly one result on the out_
// stream, with the status code in out_tuser and the task words and priorities in out_tdata.
// A call below the current priority is queued in a per-level FIFO in node memories, or
// dropped when no node is free; software drains them with repeated restores until resume.
//
// Timing. The block works on one request at a time; in_tready is high only while the
// sequencer is idle. Each request is latched, then executed; a call that queues on a
// level that already has work reads the level tail before linking the new node in, and
// a dispatching restore reads the level tail and first node, then unlinks and frees it.
// These walks make one memory access a cycle; the step that emits waits on out_busy.
//
// Reset clears the current priority to idle, empties the level bitmap and marks every node
// free; no memory clearing pass is needed, so the block takes a request right after reset.
// Results sit in an output register: the next request is accepted while a result still
// waits, and the sequencer only pauses when a second result is ready before the first is
// taken, so no result is lost or repeated while out_tready is low.
`include "assert_macros.svh"

module bitmap_priority_task_scheduler_unit
  import bpts_pkg::*;
#(
  parameter int PRIORITY_LEVELS = 32,
  parameter int NODE_COUNT      = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // cmd[1:0]
  input  logic [CMD_W-1:0]       in_tuser,
  // priority_req[4:0], prev_priority[10:5], task_func[42:11], task_message[74:43], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status[2:0]
  output logic [STAT_W-1:0]      out_tuser,
  // run_func[31:0], run_message[63:32], result_priority[69:64], now_priority[75:70], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  dp_cmd_t  dcmd;
  dp_stat_t stat;
  result_t  res;
  logic     out_valid_r;
  result_t  out_res_r;
  logic     out_busy;

  // A result still waiting in the output register blocks the next emit.
  assign out_busy = out_valid_r && !out_tready;

  bpts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .out_busy (out_busy),
    .stat     (stat),
    .dcmd     (dcmd)
  );

  bpts_dpath #(
    .PRIORITY_LEVELS (PRIORITY_LEVELS),
    .NODE_COUNT      (NODE_COUNT)
  ) u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_cmd  (in_tuser),
    .in_req  (in_tdata[4:0]),
    .in_prev (in_tdata[10:5]),
    .in_func (in_tdata[42:11]),
    .in_msg  (in_tdata[74:43]),
    .dcmd    (dcmd),
    .stat    (stat),
    .res     (res)
  );

  // Output register: valid is control state, the payload needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dcmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.emit) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {4'b0000, out_res_r.now_priority, out_res_r.result_priority,
                       out_res_r.run_message, out_res_r.run_func};

  `BPTS_NEVER(a_emit_overwrite, dcmd.emit && out_busy, "result emitted over a waiting result")
  `BPTS_ASSERT(a_one_at_a_time, (in_tvalid && in_tready) |=> !in_tready,
               "request accepted while another is in work")

endmodule
